/* design/lzs_pkg.sv */
// lzs_pkg: shared types and constants of the layer z-order stack.
// Used by the level cells, the sequencer and the top level.
package lzs_pkg;

  localparam int LAY_W = 8;
  localparam int DEP_W = 9;

  localparam logic signed [DEP_W-1:0] DEPTH_HIDDEN = -9'sd1;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_SET   = 2'd1,
    FN_FREE  = 2'd2,
    FN_NOP   = 2'd3
  } lzs_func_t;

  // Shift command broadcast to every level cell.
  typedef struct packed {
    logic             load;
    logic [LAY_W-1:0] dst;
    logic [LAY_W-1:0] lay;
    logic             move;
    logic             take_prev;
    logic [LAY_W-1:0] lo;
    logic [LAY_W-1:0] hi;
  } lzs_shift_t;

  // Allocation flag update.
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [LAY_W-1:0] idx;
  } lzs_use_t;

  // Lookup of the captured layer and of the lowest free layer.
  typedef struct packed {
    logic             lay_ok;
    logic             used;
    logic             hit;
    logic [LAY_W-1:0] level;
    logic             free_any;
    logic [LAY_W-1:0] free_idx;
  } lzs_look_t;

endpackage

/* design/lzs_in_if.sv */
// lzs_in_if: request channel of the layer z-order stack.
// Valid/ready handshake with the request fields; no dependencies.
interface lzs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [7:0]        layer;
  logic signed [8:0] want_depth;

  modport source (output valid, func, layer, want_depth, input ready);
  modport sink   (input valid, func, layer, want_depth, output ready);
endinterface

/* design/lzs_out_if.sv */
// lzs_out_if: result channel of the layer z-order stack.
// Valid/ready handshake with the result fields; no dependencies.
interface lzs_out_if;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [7:0]        layer_out;
  logic signed [8:0] new_depth;
  logic              redraw;
  logic [8:0]        map_from;
  logic [8:0]        draw_low;
  logic signed [8:0] draw_high;

  modport source (output valid, ok, layer_out, new_depth, redraw, map_from, draw_low,
                  draw_high, input ready);
  modport sink   (input valid, ok, layer_out, new_depth, redraw, map_from, draw_low,
                  draw_high, output ready);
endinterface

/* design/lzs_level_cell.sv */
// lzs_level_cell: one stacking level, holds the layer shown there.
// Loads a layer or takes its neighbor's entry on a shift; uses lzs_pkg.
module lzs_level_cell #(
  parameter int LEVEL = 0
) (
  input  logic               clk,
  input  lzs_pkg::lzs_shift_t shift,
  input  logic [7:0]         prev_id,
  input  logic [7:0]         next_id,
  output logic [7:0]         id
);
  import lzs_pkg::*;

  localparam logic [LAY_W-1:0] LVL = LAY_W'(LEVEL);

  always_ff @(posedge clk) begin
    priority if (shift.load && shift.dst == LVL) begin
      id <= shift.lay;
    end else if (shift.move && LVL >= shift.lo && LVL <= shift.hi) begin
      id <= shift.take_prev ? prev_id : next_id;
    end
  end

endmodule

/* design/lzs_seq.sv */
// lzs_seq: item sequencer, depth clamp, move decode and result register.
// Holds the top level; drives the level cells' shift command; uses lzs_pkg.
module lzs_seq (
  input  logic                clk,
  input  logic                rst,
  lzs_in_if.sink              req,
  lzs_out_if.source           rsp,
  input  lzs_pkg::lzs_look_t  look,
  output logic [7:0]          lay_q,
  output logic signed [8:0]   top_level,
  output lzs_pkg::lzs_shift_t shift,
  output lzs_pkg::lzs_use_t   use_cmd
);
  import lzs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t            state;
  lzs_func_t         func_q;
  logic signed [8:0] want_q;
  lzs_look_t         look_q;

  logic signed [9:0] old, top10, want10, tgt, lim, d;
  logic              moving, changed, lower, hide, raise, show;
  logic signed [9:0] top_next;
  logic              res_ok, res_redraw;
  logic [7:0]        res_layer;
  logic signed [9:0] res_depth, res_from, res_high;

  assign req.ready = (state == ST_IDLE);

  always_comb begin
    old    = look_q.hit ? $signed({2'b00, look_q.level}) : -10'sd1;
    top10  = $signed({top_level[8], top_level});
    want10 = $signed({want_q[8], want_q});
    tgt    = (func_q == FN_SET) ? want10 : -10'sd1;
    lim    = (old >= 0) ? top10 : top10 + 10'sd1;
    if (tgt > lim) begin
      d = lim;
    end else if (tgt < -10'sd1) begin
      d = -10'sd1;
    end else begin
      d = tgt;
    end

    moving  = look_q.lay_ok && look_q.used &&
              (func_q == FN_SET || (func_q == FN_FREE && old >= 0));
    changed = moving && (d != old);
    lower   = changed && (old > d) && (d >= 0);
    hide    = changed && (old > d) && (d < 0);
    raise   = changed && (d > old) && (old >= 0);
    show    = changed && (d > old) && (old < 0);

    top_next = top10;
    if (hide) begin
      top_next = top10 - 10'sd1;
    end else if (show) begin
      top_next = top10 + 10'sd1;
    end

    shift.load      = (state == ST_EXEC) && changed && !hide;
    shift.dst       = d[7:0];
    shift.lay       = lay_q;
    shift.take_prev = lower || show;
    shift.lo        = (lower || show) ? 8'(d + 10'sd1) : old[7:0];
    if (lower) begin
      shift.hi = old[7:0];
    end else if (show) begin
      shift.hi = 8'(top10 + 10'sd1);
    end else if (raise) begin
      shift.hi = 8'(d - 10'sd1);
    end else begin
      shift.hi = 8'(top10 - 10'sd1);
    end
    shift.move = (state == ST_EXEC) &&
                 (lower || raise || (hide && old < top10) || (show && d <= top10));

    use_cmd.set = (state == ST_EXEC) && (func_q == FN_ALLOC) && look_q.free_any;
    use_cmd.clr = (state == ST_EXEC) && (func_q == FN_FREE) && look_q.lay_ok && look_q.used;
    use_cmd.idx = (func_q == FN_ALLOC) ? look_q.free_idx : lay_q;

    res_redraw = changed;
    res_from   = '0;
    res_high   = -10'sd1;
    if (lower) begin
      res_from = d + 10'sd1;
      res_high = old;
    end else if (hide) begin
      res_high = old - 10'sd1;
    end else if (raise || show) begin
      res_from = d;
      res_high = d;
    end

    unique case (func_q)
      FN_ALLOC: begin
        res_ok    = look_q.free_any;
        res_layer = look_q.free_any ? look_q.free_idx : '0;
        res_depth = -10'sd1;
      end
      FN_NOP: begin
        res_ok    = 1'b0;
        res_layer = lay_q;
        res_depth = old;
      end
      default: begin
        res_ok    = look_q.lay_ok && look_q.used;
        res_layer = lay_q;
        res_depth = moving ? d : -10'sd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
      top_level <= DEPTH_HIDDEN;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          rsp.valid <= 1'b1;
          top_level <= top_next[8:0];
          state     <= ST_HOLD;
        end
        ST_HOLD: begin
          if (rsp.ready) begin
            rsp.valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      func_q <= lzs_func_t'(req.func);
      lay_q  <= req.layer;
      want_q <= req.want_depth;
    end
    if (state == ST_LOOK) begin
      look_q <= look;
    end
    if (state == ST_EXEC) begin
      rsp.ok        <= res_ok;
      rsp.layer_out <= res_layer;
      rsp.new_depth <= res_depth[8:0];
      rsp.redraw    <= res_redraw;
      rsp.map_from  <= res_from[8:0];
      rsp.draw_low  <= res_from[8:0];
      rsp.draw_high <= res_high[8:0];
    end
  end

  a_no_accept_while_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("request taken while result pending");

  a_top_moves_in_exec: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EXEC) |=> $stable(top_level))
    else $error("top level changed outside execute");

  a_top_floor: assert property (@(posedge clk) disable iff (rst)
    top_level >= DEPTH_HIDDEN)
    else $error("top level below hidden");

  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_EXEC))
    else $error("result raised without execute");

  a_redraw_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.redraw) |-> rsp.ok)
    else $error("redraw on refused item");

endmodule

/* design/layer_zorder_stack.sv */
// layer_zorder_stack: pool of display layers and their stacking order.
// Uses lzs_pkg, lzs_in_if, lzs_out_if, lzs_level_cell and lzs_seq.
//
//   channel  dir  fields
//   req      in   func, layer, want_depth
//   rsp      out  ok, layer_out, new_depth, redraw, map_from, draw_low, draw_high
//
// An accepted item passes through lookup (match against the level cells and
// lowest-free pick), then execute, in which the row of level cells shifts by
// one place and the result register loads. The next item is accepted the cycle
// after the result is taken, so no new item is taken while one is in flight;
// rsp stalls hold the result and block req.
// Reset (rst, synchronous) hides all layers and frees them.
module layer_zorder_stack #(
  parameter int NUM_LAYERS = 256
) (
  input  logic      clk,
  input  logic      rst,
  lzs_in_if.sink    req,
  lzs_out_if.source rsp
);
  import lzs_pkg::*;

  localparam int LW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

  logic [LAY_W-1:0]      ids [NUM_LAYERS];
  logic [NUM_LAYERS-1:0] in_use, free_vec, free_low;
  logic [LAY_W-1:0]      lay_q;
  logic signed [8:0]     top_level;
  lzs_shift_t            shift;
  lzs_use_t              use_cmd;
  lzs_look_t             look;

  for (genvar h = 0; h < NUM_LAYERS; h++) begin : g_level
    lzs_level_cell #(.LEVEL(h)) u_cell (
      .clk     (clk),
      .shift   (shift),
      .prev_id (ids[(h > 0) ? h - 1 : h]),
      .next_id (ids[(h < NUM_LAYERS - 1) ? h + 1 : h]),
      .id      (ids[h])
    );
  end

  lzs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .look      (look),
    .lay_q     (lay_q),
    .top_level (top_level),
    .shift     (shift),
    .use_cmd   (use_cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      if (use_cmd.set) begin
        in_use[use_cmd.idx[LW-1:0]] <= 1'b1;
      end
      if (use_cmd.clr) begin
        in_use[use_cmd.idx[LW-1:0]] <= 1'b0;
      end
    end
  end

  // lowest free layer isolated as a one-hot word
  assign free_vec = ~in_use;
  assign free_low = free_vec & (~free_vec + {{(NUM_LAYERS-1){1'b0}}, 1'b1});

  always_comb begin
    look.lay_ok   = ({1'b0, lay_q} < 9'(NUM_LAYERS));
    look.used     = look.lay_ok && in_use[lay_q[LW-1:0]];
    look.free_any = |free_vec;
    look.hit      = 1'b0;
    look.level    = '0;
    look.free_idx = '0;
    for (int h = 0; h < NUM_LAYERS; h++) begin
      if (!top_level[8] && LAY_W'(h) <= top_level[7:0] && ids[h] == lay_q) begin
        look.hit   = 1'b1;
        look.level = look.level | LAY_W'(h);
      end
      if (free_low[h]) begin
        look.free_idx = look.free_idx | LAY_W'(h);
      end
    end
  end

endmodule

/* bench/zorder_checker.sv */
`timescale 1ns / 1ps
// zorder_checker: watches the req and rsp channels of layer_zorder_stack, predicts
// every result from its own copy of the stacking order and compares it field by field.
// Depends on lzs_pkg, lzs_in_if and lzs_out_if.
module zorder_checker (
  input  logic clk,
  input  logic rst,
  lzs_in_if    req,
  lzs_out_if   rsp,
  output int   fail_cnt,
  output int   pending
);
  import lzs_pkg::*;

  localparam int NUM_LAYERS = 256;

  typedef struct packed {
    logic                    ok;
    logic [LAY_W-1:0]        lay;
    logic signed [DEP_W-1:0] depth;
    logic                    redraw;
    logic [DEP_W-1:0]        map_from;
    logic [DEP_W-1:0]        draw_low;
    logic signed [DEP_W-1:0] draw_high;
  } zres_t;

  logic [LAY_W-1:0] layer_at [0:NUM_LAYERS-1];
  int               depth_of [0:NUM_LAYERS-1];
  bit               owned    [0:NUM_LAYERS-1];
  int               top_lvl;
  zres_t            due_rsp[$];

  function automatic zres_t mk_res(input logic ok, input int lay, input int nd, input logic rd,
                                   input int mf, input int dl, input int dh);
    zres_t r;
    r.ok        = ok;
    r.lay       = lay[LAY_W-1:0];
    r.depth     = nd[DEP_W-1:0];
    r.redraw    = rd;
    r.map_from  = mf[DEP_W-1:0];
    r.draw_low  = dl[DEP_W-1:0];
    r.draw_high = dh[DEP_W-1:0];
    return r;
  endfunction

  // Move an owned layer to a clamped level, shifting the layers in between.
  task automatic restack(input int lay, input int want, output zres_t r);
    int old;
    int d;
    int lim;
    int h;
    old = depth_of[lay];
    lim = (old >= 0) ? top_lvl : top_lvl + 1;
    d = want;
    if (d > lim) d = lim;
    if (d < -1) d = -1;
    if (d == old) begin
      r = mk_res(1'b1, lay, old, 1'b0, 0, 0, -1);
      return;
    end
    depth_of[lay] = d;
    if (old > d) begin
      if (d >= 0) begin
        for (h = old; h > d; h--) begin
          layer_at[h] = layer_at[h-1];
          depth_of[layer_at[h]] = h;
        end
        layer_at[d] = lay[LAY_W-1:0];
        r = mk_res(1'b1, lay, d, 1'b1, d + 1, d + 1, old);
      end else begin
        for (h = old; h < top_lvl; h++) begin
          layer_at[h] = layer_at[h+1];
          depth_of[layer_at[h]] = h;
        end
        top_lvl--;
        r = mk_res(1'b1, lay, -1, 1'b1, 0, 0, old - 1);
      end
    end else begin
      if (old >= 0) begin
        for (h = old; h < d; h++) begin
          layer_at[h] = layer_at[h+1];
          depth_of[layer_at[h]] = h;
        end
      end else begin
        for (h = top_lvl; h >= d; h--) begin
          if (h + 1 < NUM_LAYERS) begin
            layer_at[h+1] = layer_at[h];
            depth_of[layer_at[h+1]] = h + 1;
          end
        end
        top_lvl++;
      end
      layer_at[d] = lay[LAY_W-1:0];
      r = mk_res(1'b1, lay, d, 1'b1, d, d, d);
    end
  endtask

  task automatic stack_step(input logic [1:0] fn, input logic [LAY_W-1:0] lay,
                            input logic signed [DEP_W-1:0] want, output zres_t r);
    int li;
    int i;
    li = int'(lay);
    case (lzs_func_t'(fn))
      FN_ALLOC: begin
        r = mk_res(1'b0, 0, -1, 1'b0, 0, 0, -1);
        for (i = 0; i < NUM_LAYERS; i++) begin
          if (!owned[i]) begin
            owned[i] = 1'b1;
            depth_of[i] = -1;
            r = mk_res(1'b1, i, -1, 1'b0, 0, 0, -1);
            break;
          end
        end
      end
      FN_NOP: begin
        r = mk_res(1'b0, li, depth_of[li], 1'b0, 0, 0, -1);
      end
      default: begin
        if (!owned[li]) begin
          r = mk_res(1'b0, li, -1, 1'b0, 0, 0, -1);
        end else if (lzs_func_t'(fn) == FN_SET) begin
          restack(li, int'(want), r);
        end else begin
          if (depth_of[li] >= 0) restack(li, -1, r);
          else r = mk_res(1'b1, li, -1, 1'b0, 0, 0, -1);
          owned[li] = 1'b0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    zres_t exp_r;
    zres_t got_r;
    int    i;
    if (rst) begin
      for (i = 0; i < NUM_LAYERS; i++) begin
        layer_at[i] = '0;
        depth_of[i] = -1;
        owned[i]    = 1'b0;
      end
      top_lvl = -1;
      due_rsp.delete();
      fail_cnt = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got_r.ok        = rsp.ok;
        got_r.lay       = rsp.layer_out;
        got_r.depth     = rsp.new_depth;
        got_r.redraw    = rsp.redraw;
        got_r.map_from  = rsp.map_from;
        got_r.draw_low  = rsp.draw_low;
        got_r.draw_high = rsp.draw_high;
        if (due_rsp.size() == 0) begin
          if (fail_cnt < 10)
            $display("unexpected result: layer=%0d depth=%0d", got_r.lay, got_r.depth);
          fail_cnt++;
        end else begin
          exp_r = due_rsp.pop_front();
          if (got_r !== exp_r) begin
            if (fail_cnt < 10) begin
              $display("mismatch: exp ok=%0d lay=%0d dep=%0d rd=%0d map=%0d draw=%0d..%0d",
                       exp_r.ok, exp_r.lay, exp_r.depth, exp_r.redraw, exp_r.map_from,
                       exp_r.draw_low, exp_r.draw_high);
              $display("          got ok=%0d lay=%0d dep=%0d rd=%0d map=%0d draw=%0d..%0d",
                       got_r.ok, got_r.lay, got_r.depth, got_r.redraw, got_r.map_from,
                       got_r.draw_low, got_r.draw_high);
            end
            fail_cnt++;
          end
        end
      end
      if (req.valid && req.ready) begin
        stack_step(req.func, req.layer, req.want_depth, exp_r);
        due_rsp.push_back(exp_r);
      end
    end
    pending = due_rsp.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: drives requests into layer_zorder_stack with random gaps and stalls,
// and gives the verdict from the failure count of zorder_checker.
// Depends on lzs_pkg, lzs_in_if, lzs_out_if, layer_zorder_stack and zorder_checker.
module tb_top;
  import lzs_pkg::*;

  localparam int N_ITEMS   = 1450;
  localparam int CYC_LIMIT = 800000;

  logic clk = 1'b0;
  logic rst;
  int   fails;
  int   pend;
  int   cyc = 0;
  int   n_items = 0;
  int   last_alloc;
  bit   calm = 1'b0;
  bit   rx_hold = 1'b0;
  int   rx_gap = 0;
  bit [255:0] alloc_map = '0;
  bit [255:0] shown_map = '0;

  lzs_in_if  req_ch ();
  lzs_out_if rsp_ch ();

  layer_zorder_stack u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  zorder_checker u_chk (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .fail_cnt (fails),
    .pending  (pend)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls, plus one long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        rsp_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_gap--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap = gap_len();
      end
    end
  end

  initial begin
    wait (n_items >= 180);
    rx_hold = 1'b1;
    repeat (600) @(negedge clk);
    rx_hold = 1'b0;
  end

  task automatic issue(input lzs_func_t fn, input int lay, input int want);
    int k;
    int g;
    if (fn == FN_ALLOC) begin
      last_alloc = -1;
      for (k = 0; k < 256; k++) begin
        if (!alloc_map[k]) begin
          alloc_map[k] = 1'b1;
          shown_map[k] = 1'b0;
          last_alloc = k;
          break;
        end
      end
    end else if (fn == FN_SET && alloc_map[lay]) begin
      shown_map[lay] = (want >= 0);
    end else if (fn == FN_FREE && alloc_map[lay]) begin
      alloc_map[lay] = 1'b0;
      shown_map[lay] = 1'b0;
    end
    n_items++;
    if (n_items % 50 == 0) calm = ($urandom_range(0, 3) == 0);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req_ch.func       <= fn;
    req_ch.layer      <= lay[7:0];
    req_ch.want_depth <= want[8:0];
    req_ch.valid      <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (pend == 0);
  endtask

  task automatic rand_item();
    int r;
    int w;
    int lay;
    int want;
    int hi;
    int k;
    int sc;
    sc = $countones(shown_map);
    hi = -1;
    for (k = 0; k < 256; k++)
      if (alloc_map[k]) hi = k;
    lay = $urandom_range(0, 255);
    if (hi >= 0) begin
      for (k = 0; k < 32; k++) begin
        lay = $urandom_range(0, hi);
        if (alloc_map[lay]) break;
      end
    end
    w = $urandom_range(0, 99);
    if (w < 15) want = -1;
    else if (w < 20) want = -int'($urandom_range(2, 256));
    else if (w < 30) want = $urandom_range(sc, 255);
    else want = $urandom_range(0, sc + 1);
    r = $urandom_range(0, 99);
    if (r < 16) issue(FN_ALLOC, $urandom_range(0, 255), want);
    else if (r < 74) issue(FN_SET, lay, want);
    else if (r < 86) issue(FN_FREE, lay, want);
    else if (r < 93) issue(FN_NOP, $urandom_range(0, 255), want);
    else issue($urandom_range(0, 1) ? FN_SET : FN_FREE, $urandom_range(0, 255), want);
  endtask

  initial begin
    int i;
    rst = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.func       = FN_ALLOC;
    req_ch.layer      = '0;
    req_ch.want_depth = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: refusals, clamps, raise, lower, hide, dispose
    issue(FN_NOP, 0, 0);
    issue(FN_SET, 5, 3);
    issue(FN_FREE, 255, -1);
    issue(FN_NOP, 255, 255);
    issue(FN_ALLOC, 0, 0);
    issue(FN_ALLOC, 255, -256);
    issue(FN_ALLOC, 170, 85);
    issue(FN_ALLOC, 85, -171);
    issue(FN_SET, 0, 255);
    issue(FN_SET, 1, 0);
    issue(FN_SET, 2, 255);
    issue(FN_SET, 3, -256);
    issue(FN_SET, 3, 1);
    issue(FN_SET, 0, 255);
    issue(FN_SET, 2, 0);
    issue(FN_SET, 2, 0);
    issue(FN_SET, 1, -1);
    issue(FN_SET, 0, -200);
    issue(FN_NOP, 2, 0);
    issue(FN_FREE, 2, 0);
    issue(FN_FREE, 1, 0);
    issue(FN_SET, 2, 0);
    issue(FN_ALLOC, 0, 0);

    repeat (450) rand_item();

    // fill the pool, showing most layers, then overflow it
    while (alloc_map != '1) begin
      issue(FN_ALLOC, $urandom_range(0, 255), 0);
      if ($urandom_range(0, 9) != 0)
        issue(FN_SET, last_alloc, $urandom_range(0, $countones(shown_map) + 1));
    end
    repeat (3) issue(FN_ALLOC, $urandom_range(0, 255), 0);
    drain();

    for (i = 0; i < 256; i++)
      if (!shown_map[i]) issue(FN_SET, i, 255);
    issue(FN_SET, $urandom_range(0, 255), 255);
    issue(FN_SET, $urandom_range(0, 255), 0);
    issue(FN_SET, $urandom_range(0, 255), 254);

    while (n_items < N_ITEMS) rand_item();

    drain();
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lzs_pkg.sv
design/lzs_in_if.sv
design/lzs_out_if.sv
design/lzs_level_cell.sv
design/lzs_seq.sv
design/layer_zorder_stack.sv
bench/zorder_checker.sv
bench/tb_top.sv
